@@ hw/rtl/pidvf_pkg.sv @@
package pidvf_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Field and state widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned RATE_W    = 48;
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Shift-add multiplier: a magnitude of up to RATE_W + 1 bits times a 32-bit
  // multiplier, retired DIGIT_W multiplier bits per cycle.
  localparam int unsigned DIGIT_W    = 2;
  localparam int unsigned MCAND_W    = RATE_W + 1;
  localparam int unsigned HI_W       = MCAND_W + DIGIT_W;
  localparam int unsigned PROD_W     = MCAND_W + DATA_W;
  localparam int unsigned PREG_W     = HI_W + DATA_W;
  localparam int unsigned MUL_STEPS  = DATA_W / DIGIT_W;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_STEPS);

  // Control value accumulation: the trapezoid increment saturates at 2^62.
  localparam int unsigned CTL_W     = 64;
  localparam int unsigned CTL_MAG_W = 63;
  localparam logic [CTL_MAG_W-1:0] CTL_SAT = {1'b1, {(CTL_MAG_W-1){1'b0}}};

  // Register reset values.
  localparam logic signed [DATA_W-1:0] GAIN_RST          = '0;
  localparam logic        [LIMIT_W-1:0] INTEG_LIMIT_RST  = '1;
  localparam logic signed [DATA_W-1:0] CONTROL_MIN_RST   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] CONTROL_MAX_RST   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] CONTROL_START_RST = '0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_UPDATE  = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP      = 3'd0,
    CFG_GAIN_INTEG     = 3'd1,
    CFG_GAIN_DERIV     = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_CONTROL_MIN    = 3'd4,
    CFG_CONTROL_MAX    = 3'd5,
    CFG_CONTROL_START  = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_LOAD,
    ST_MUL_TRIPLE,
    ST_MUL_RUN,
    ST_MUL_POST,
    ST_DIV_WAIT,
    ST_RATE,
    ST_RSUM,
    ST_CLAMP,
    ST_FINISH
  } state_e;

  // Which product the shared multiplier is working on.
  typedef enum logic [2:0] {
    PH_INTEG,
    PH_KP,
    PH_KI,
    PH_KD,
    PH_CTL
  } phase_e;

endpackage

@@ hw/rtl/pid_velocity_form_trapezoid.sv @@
// Update transaction (opcode update, non-zero time step): five products go through one
// shift-add multiplier retiring two bits a cycle; the 33+FracBits step divider runs beside the
// first three, and the update waits for it if it finishes late. Other transactions skip the
// multiplier. A transaction is taken once the previous result is in the output register.
// Reset (rst_ni low, asynchronous) loads defaults and clears the history.
module pid_velocity_form_trapezoid #(
  parameter int unsigned FracBits = pidvf_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pidvf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pidvf_pkg::DATA_W-1:0]          cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [pidvf_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic signed [pidvf_pkg::DATA_W-1:0]   error_sample_i,
  input  logic [pidvf_pkg::DATA_W-1:0]          time_step_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pidvf_pkg::DATA_W-1:0]   control_value_o
);

  localparam int unsigned DW = pidvf_pkg::DATA_W;
  localparam int unsigned RW = pidvf_pkg::RATE_W;
  localparam int unsigned MW = pidvf_pkg::MCAND_W;
  localparam int unsigned HW = pidvf_pkg::HI_W;
  localparam int unsigned PW = pidvf_pkg::PROD_W;
  localparam int unsigned QW = pidvf_pkg::PREG_W;
  localparam int unsigned CW = pidvf_pkg::CTL_W;

  // Magnitude of a 32x32 product scaled down by 2^FracBits or 2^(FracBits+1).
  localparam int unsigned ShMagW  = 2 * DW - 1 - FracBits;
  localparam int unsigned IntegW  = ShMagW + 2;
  localparam int unsigned RateW   = (ShMagW + 2 > RW + 1) ? ShMagW + 2 : RW + 1;
  localparam int unsigned DivW    = DW + 1 + FracBits;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam logic signed [RateW-1:0] RateMax = {{(RateW-RW+1){1'b0}}, {(RW-1){1'b1}}};
  localparam logic signed [RateW-1:0] RateMin = {{(RateW-RW+1){1'b1}}, {(RW-1){1'b0}}};
  localparam logic [DivW-1:0] DivPosMax = {{(DivW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [DivW-1:0] DivNegMax = {{(DivW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

  function automatic logic [DW-1:0] abs32(input logic signed [DW-1:0] v);
    abs32 = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // Configuration registers
  logic signed [DW-1:0]                  gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [pidvf_pkg::LIMIT_W-1:0]         integ_limit_q;
  logic signed [DW-1:0]                  control_min_q, control_max_q, control_start_q;

  // Controller history
  logic signed [DW-1:0]                  prev_error_q, integ_acc_q, held_control_q;
  logic signed [RW-1:0]                  prev_rate_q;

  // Transaction and working registers
  pidvf_pkg::state_e                     state_q, state_d;
  pidvf_pkg::phase_e                     phase_q;
  logic [pidvf_pkg::OPCODE_W-1:0]        opcode_q;
  logic signed [DW-1:0]                  error_q;
  logic [DW-1:0]                         dt_q;
  logic signed [DW:0]                    esum_q, ediff_q;
  logic signed [DW-1:0]                  integ_new_q;
  logic signed [RateW-1:0]               rate_acc_q;
  logic signed [RW-1:0]                  rate_q;
  logic signed [RW:0]                    rsum_q;
  logic signed [CW-1:0]                  ctl_sum_q;

  // Multiplier
  logic [MW-1:0]                         mul_m_q;
  logic [HW-1:0]                         mul_m3_q;
  logic [QW-1:0]                         mul_p_q;
  logic                                  mul_neg_q;
  logic [pidvf_pkg::MUL_CNT_W-1:0]       mul_cnt_q;

  // Divider
  logic [DW-1:0]                         div_rem_q;
  logic [DivW-1:0]                       div_quo_q;
  logic [DivCntW-1:0]                    div_cnt_q;
  logic                                  div_busy_q, div_neg_q;

  // Output register
  logic                                  out_valid_q;
  logic signed [DW-1:0]                  out_q;

  // Control strobes
  logic in_accept, is_update, div_start, fin_load, mul_last;

  // Combinational datapath
  logic signed [MW-1:0]      mc_val;
  logic [MW-1:0]             mc_mag;
  logic [DW-1:0]             mp_mag;
  logic                      mp_neg;
  logic [DivW-1:0]           dq_sat;
  logic [HW-1:0]             mul_addend, mul_sum;
  logic [PW-1:0]             prod, prod_sh1, prod_sh0;
  logic signed [IntegW-1:0]  inc_s, integ_sum, lim_s;
  logic signed [DW-1:0]      integ_clamped;
  logic signed [RateW-1:0]   term_s, rate_base;
  logic [pidvf_pkg::CTL_MAG_W-1:0] ctl_mag;
  logic signed [CW-1:0]      ctl_inc_s, cmin_s, cmax_s;
  logic signed [DW-1:0]      ctl_clamped;
  logic [DW:0]               rem_sh;
  logic                      div_ge;
  logic [DW:0]               ediff_mag;

  assign in_accept = in_valid_i && in_ready_o;
  assign is_update = (opcode_q == pidvf_pkg::OP_UPDATE) && (dt_q != '0);
  assign mul_last  = (mul_cnt_q == pidvf_pkg::MUL_CNT_W'(pidvf_pkg::MUL_STEPS - 1));

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pidvf_pkg::ST_IDLE:       if (in_accept) state_d = pidvf_pkg::ST_PREP;
      pidvf_pkg::ST_PREP:       state_d = is_update ? pidvf_pkg::ST_MUL_LOAD
                                                    : pidvf_pkg::ST_FINISH;
      pidvf_pkg::ST_MUL_LOAD:   state_d = pidvf_pkg::ST_MUL_TRIPLE;
      pidvf_pkg::ST_MUL_TRIPLE: state_d = pidvf_pkg::ST_MUL_RUN;
      pidvf_pkg::ST_MUL_RUN:    if (mul_last) state_d = pidvf_pkg::ST_MUL_POST;
      pidvf_pkg::ST_MUL_POST: begin
        unique case (phase_q)
          pidvf_pkg::PH_INTEG,
          pidvf_pkg::PH_KP: state_d = pidvf_pkg::ST_MUL_LOAD;
          pidvf_pkg::PH_KI: state_d = pidvf_pkg::ST_DIV_WAIT;
          pidvf_pkg::PH_KD: state_d = pidvf_pkg::ST_RATE;
          default:          state_d = pidvf_pkg::ST_CLAMP;
        endcase
      end
      pidvf_pkg::ST_DIV_WAIT:   if (!div_busy_q) state_d = pidvf_pkg::ST_MUL_LOAD;
      pidvf_pkg::ST_RATE:       state_d = pidvf_pkg::ST_RSUM;
      pidvf_pkg::ST_RSUM:       state_d = pidvf_pkg::ST_MUL_LOAD;
      pidvf_pkg::ST_CLAMP:      state_d = pidvf_pkg::ST_FINISH;
      pidvf_pkg::ST_FINISH:     if (fin_load) state_d = pidvf_pkg::ST_IDLE;
      default:                  state_d = pidvf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == pidvf_pkg::ST_IDLE);
    div_start  = (state_q == pidvf_pkg::ST_MUL_LOAD) && (phase_q == pidvf_pkg::PH_INTEG);
    fin_load   = (state_q == pidvf_pkg::ST_FINISH) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidvf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- operands
  always_comb begin
    // The quotient saturates to the signed 32-bit range of the derivative.
    if (!div_neg_q && (div_quo_q > DivPosMax)) begin
      dq_sat = DivPosMax;
    end else if (div_neg_q && (div_quo_q > DivNegMax)) begin
      dq_sat = DivNegMax;
    end else begin
      dq_sat = div_quo_q;
    end

    unique case (phase_q)
      pidvf_pkg::PH_INTEG: begin
        mc_val = MW'(esum_q);
        mp_mag = dt_q;
        mp_neg = 1'b0;
      end
      pidvf_pkg::PH_KP: begin
        mc_val = MW'(gain_prop_q);
        mp_mag = abs32(error_q);
        mp_neg = error_q[DW-1];
      end
      pidvf_pkg::PH_KI: begin
        mc_val = MW'(gain_integ_q);
        mp_mag = abs32(integ_new_q);
        mp_neg = integ_new_q[DW-1];
      end
      pidvf_pkg::PH_KD: begin
        mc_val = MW'(gain_deriv_q);
        mp_mag = dq_sat[DW-1:0];
        mp_neg = div_neg_q;
      end
      default: begin
        mc_val = MW'(rsum_q);
        mp_mag = dt_q;
        mp_neg = 1'b0;
      end
    endcase
    mc_mag = mc_val[MW-1] ? MW'(-mc_val) : MW'(mc_val);
  end

  // ---------------------------------------------------------------- multiplier step
  always_comb begin
    unique case (mul_p_q[pidvf_pkg::DIGIT_W-1:0])
      2'd0:    mul_addend = '0;
      2'd1:    mul_addend = HW'(mul_m_q);
      2'd2:    mul_addend = HW'({mul_m_q, 1'b0});
      default: mul_addend = mul_m3_q;
    endcase
    // The partial product stays below the multiplicand, so the sum cannot overflow.
    mul_sum = mul_p_q[QW-1:DW] + mul_addend;
  end

  // ---------------------------------------------------------------- post-processing
  always_comb begin
    prod     = mul_p_q[PW-1:0];
    prod_sh0 = prod >> FracBits;
    prod_sh1 = prod >> (FracBits + 1);

    inc_s     = signed'(IntegW'(prod_sh1[ShMagW-1:0]));
    integ_sum = IntegW'(integ_acc_q) + (mul_neg_q ? -inc_s : inc_s);
    lim_s     = signed'(IntegW'(integ_limit_q));
    if (integ_sum < -lim_s) begin
      integ_clamped = DW'(-lim_s);
    end else if (integ_sum > lim_s) begin
      integ_clamped = DW'(lim_s);
    end else begin
      integ_clamped = DW'(integ_sum);
    end

    term_s    = signed'(RateW'(prod_sh0[ShMagW-1:0]));
    rate_base = (phase_q == pidvf_pkg::PH_KP) ? '0 : rate_acc_q;

    if (prod_sh1 > PW'(pidvf_pkg::CTL_SAT)) begin
      ctl_mag = pidvf_pkg::CTL_SAT;
    end else begin
      ctl_mag = prod_sh1[pidvf_pkg::CTL_MAG_W-1:0];
    end
    ctl_inc_s = signed'({1'b0, ctl_mag});

    // Lower clamp first: with crossed limits, values below control_min get control_min, all others control_max.
    cmin_s = CW'(control_min_q);
    cmax_s = CW'(control_max_q);
    if (ctl_sum_q < cmin_s) begin
      ctl_clamped = control_min_q;
    end else if (ctl_sum_q > cmax_s) begin
      ctl_clamped = control_max_q;
    end else begin
      ctl_clamped = ctl_sum_q[DW-1:0];
    end
  end

  // ---------------------------------------------------------------- divider step
  always_comb begin
    rem_sh    = {div_rem_q, div_quo_q[DivW-1]};
    div_ge    = (rem_sh >= {1'b0, dt_q});
    ediff_mag = ediff_q[DW] ? (DW+1)'(-ediff_q) : (DW+1)'(ediff_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
    end else if (div_start) begin
      div_busy_q <= 1'b1;
    end else if (div_busy_q && (div_cnt_q == DivCntW'(DivW - 1))) begin
      div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_rem_q <= '0;
      div_quo_q <= DivW'(ediff_mag) << FracBits;
      div_cnt_q <= '0;
      div_neg_q <= ediff_q[DW];
    end else if (div_busy_q) begin
      div_rem_q <= div_ge ? DW'(rem_sh - {1'b0, dt_q}) : DW'(rem_sh);
      div_quo_q <= {div_quo_q[DivW-2:0], div_ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q     <= pidvf_pkg::GAIN_RST;
      gain_integ_q    <= pidvf_pkg::GAIN_RST;
      gain_deriv_q    <= pidvf_pkg::GAIN_RST;
      integ_limit_q   <= pidvf_pkg::INTEG_LIMIT_RST;
      control_min_q   <= pidvf_pkg::CONTROL_MIN_RST;
      control_max_q   <= pidvf_pkg::CONTROL_MAX_RST;
      control_start_q <= pidvf_pkg::CONTROL_START_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pidvf_pkg::CFG_GAIN_PROP:      gain_prop_q     <= cfg_wdata_i;
        pidvf_pkg::CFG_GAIN_INTEG:     gain_integ_q    <= cfg_wdata_i;
        pidvf_pkg::CFG_GAIN_DERIV:     gain_deriv_q    <= cfg_wdata_i;
        pidvf_pkg::CFG_INTEGRAL_LIMIT: integ_limit_q   <= cfg_wdata_i[pidvf_pkg::LIMIT_W-1:0];
        pidvf_pkg::CFG_CONTROL_MIN:    control_min_q   <= cfg_wdata_i;
        pidvf_pkg::CFG_CONTROL_MAX:    control_max_q   <= cfg_wdata_i;
        pidvf_pkg::CFG_CONTROL_START:  control_start_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_error_q   <= '0;
      prev_rate_q    <= '0;
      integ_acc_q    <= '0;
      held_control_q <= pidvf_pkg::CONTROL_START_RST;
    end else if (state_q == pidvf_pkg::ST_PREP) begin
      unique case (opcode_q)
        pidvf_pkg::OP_CLEAR: begin
          prev_error_q <= '0;
          prev_rate_q  <= '0;
          integ_acc_q  <= '0;
        end
        pidvf_pkg::OP_RESTART: begin
          prev_error_q   <= '0;
          prev_rate_q    <= '0;
          integ_acc_q    <= '0;
          held_control_q <= control_start_q;
        end
        default: ;
      endcase
    end else if (state_q == pidvf_pkg::ST_CLAMP) begin
      prev_error_q   <= error_q;
      prev_rate_q    <= rate_q;
      integ_acc_q    <= integ_new_q;
      held_control_q <= ctl_clamped;
    end
  end

  // ---------------------------------------------------------------- working datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pidvf_pkg::PH_INTEG;
    end else if (state_q == pidvf_pkg::ST_PREP) begin
      phase_q <= pidvf_pkg::PH_INTEG;
    end else if (state_q == pidvf_pkg::ST_MUL_POST) begin
      unique case (phase_q)
        pidvf_pkg::PH_INTEG: phase_q <= pidvf_pkg::PH_KP;
        pidvf_pkg::PH_KP:    phase_q <= pidvf_pkg::PH_KI;
        pidvf_pkg::PH_KI:    phase_q <= pidvf_pkg::PH_KD;
        default:             phase_q <= pidvf_pkg::PH_CTL;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q <= opcode_i;
      error_q  <= error_sample_i;
      dt_q     <= time_step_i;
    end
    unique case (state_q)
      pidvf_pkg::ST_PREP: begin
        esum_q  <= (DW+1)'(prev_error_q) + (DW+1)'(error_q);
        ediff_q <= (DW+1)'(error_q) - (DW+1)'(prev_error_q);
      end
      pidvf_pkg::ST_MUL_LOAD: begin
        mul_m_q   <= mc_mag;
        mul_p_q   <= QW'(mp_mag);
        mul_neg_q <= mc_val[MW-1] ^ mp_neg;
        mul_cnt_q <= '0;
      end
      pidvf_pkg::ST_MUL_TRIPLE: begin
        mul_m3_q <= HW'(mul_m_q) + HW'({mul_m_q, 1'b0});
      end
      pidvf_pkg::ST_MUL_RUN: begin
        mul_p_q   <= {{pidvf_pkg::DIGIT_W{1'b0}}, mul_sum,
                      mul_p_q[DW-1:pidvf_pkg::DIGIT_W]};
        mul_cnt_q <= mul_cnt_q + 1'b1;
      end
      pidvf_pkg::ST_MUL_POST: begin
        unique case (phase_q)
          pidvf_pkg::PH_INTEG: integ_new_q <= integ_clamped;
          pidvf_pkg::PH_KP,
          pidvf_pkg::PH_KI,
          pidvf_pkg::PH_KD:    rate_acc_q <= rate_base + (mul_neg_q ? -term_s : term_s);
          default:             ctl_sum_q <= CW'(held_control_q)
                                            + (mul_neg_q ? -ctl_inc_s : ctl_inc_s);
        endcase
      end
      pidvf_pkg::ST_RATE: begin
        if (rate_acc_q > RateMax) begin
          rate_q <= RateMax[RW-1:0];
        end else if (rate_acc_q < RateMin) begin
          rate_q <= RateMin[RW-1:0];
        end else begin
          rate_q <= rate_acc_q[RW-1:0];
        end
      end
      pidvf_pkg::ST_RSUM: begin
        rsum_q <= (RW+1)'(prev_rate_q) + (RW+1)'(rate_q);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_q <= held_control_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign control_value_o = out_q;

endmodule

@@ hw/rtl/pidvf_checker.sv @@
module pidvf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [pidvf_pkg::DATA_W-1:0] control_value_o
);

  // Transactions taken in but not yet delivered: at most one in flight and one waiting.
  logic [1:0] outstanding_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(control_value_o))
    else $error("result changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("new transaction taken while one is being worked on");

  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result presented while the block is still busy");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outstanding_q != 2'd0)
    else $error("result presented without a pending transaction");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> outstanding_q == 2'd0 || outstanding_q == 2'd1)
    else $error("too many transactions outstanding");

endmodule

bind pid_velocity_form_trapezoid pidvf_checker u_pidvf_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import pidvf_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam bit [63:0] SAT62 = 64'h4000_0000_0000_0000;
  localparam longint RATE_MAX = (64'sd1 <<< 47) - 1;
  localparam longint RATE_MIN = -(64'sd1 <<< 47);
  localparam longint DIFF_MAX = (64'sd1 <<< 31) - 1;
  localparam longint DIFF_MIN = -(64'sd1 <<< 31);

  typedef struct {
    logic [OPCODE_W-1:0]      op;
    logic signed [DATA_W-1:0] err;
    logic [DATA_W-1:0]        dt;
  } pid_cmd_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [DATA_W-1:0]        cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [OPCODE_W-1:0]      opcode_i = '0;
  logic signed [DATA_W-1:0] error_sample_i = '0;
  logic [DATA_W-1:0]        time_step_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] control_value_o;

  // Controller copy: registers and history, at their reset values.
  longint gain_p = 0, gain_i = 0, gain_d = 0;
  longint integ_lim = 64'h7fff_ffff;
  longint ctl_lo = -(64'sd1 <<< 31), ctl_hi = (64'sd1 <<< 31) - 1, ctl_start = 0;
  longint last_err = 0, last_rate = 0, integ_sum = 0, ctl_held = 0;

  pid_cmd_t                 cmd_queue[$];
  pid_cmd_t                 cur_cmd;
  logic signed [DATA_W-1:0] expected_controls[$];
  logic signed [DATA_W-1:0] want;
  int unsigned              issued_count = 0;
  int unsigned              done_count = 0;
  int unsigned              fail_count = 0;
  int unsigned              cycle_count = 0;
  bit                       calm = 1'b0;

  pid_velocity_form_trapezoid uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .error_sample_i  (error_sample_i),
    .time_step_i     (time_step_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .control_value_o (control_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL pid_velocity_form_trapezoid");
      $finish;
    end
  end

  // trunc(a * b / 2^s) on magnitudes, saturated to 2^62.
  function automatic longint scaled_product(longint a, bit [63:0] b, int unsigned s);
    bit        neg;
    bit [63:0] mag, plo, mid, low32, r;
    neg = (a < 0);
    mag = neg ? -a : a;
    plo = (mag & 64'hffff_ffff) * b;
    mid = (mag >> 32) * b + (plo >> 32);
    low32 = plo & 64'hffff_ffff;
    if (s >= 32) begin
      r = mid >> (s - 32);
    end else if (mid > (SAT62 >> (32 - s))) begin
      r = SAT62;
    end else begin
      r = (mid << (32 - s)) + (low32 >> s);
    end
    if (r > SAT62) begin
      r = SAT62;
    end
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic longint gain_term(longint g, longint x);
    if (x < 0) begin
      return scaled_product(-g, -x, FB);
    end
    return scaled_product(g, x, FB);
  endfunction

  function automatic logic signed [DATA_W-1:0] next_control(pid_cmd_t c);
    longint    e, integ, num, diff, rate, ctl;
    bit [63:0] dt, anum, q;
    e = c.err;
    dt = c.dt;
    if (c.op == OP_CLEAR || c.op == OP_RESTART) begin
      if (c.op == OP_RESTART) begin
        ctl_held = ctl_start;
      end
      last_err = 0;
      last_rate = 0;
      integ_sum = 0;
    end else if (c.op == OP_UPDATE && dt != 0) begin
      integ = integ_sum + scaled_product(last_err + e, dt, FB + 1);
      if (integ < -integ_lim) begin
        integ = -integ_lim;
      end else if (integ > integ_lim) begin
        integ = integ_lim;
      end
      num = e - last_err;
      anum = (num < 0) ? -num : num;
      q = (anum << FB) / dt;
      diff = (num < 0) ? -$signed(q) : $signed(q);
      if (diff < DIFF_MIN) begin
        diff = DIFF_MIN;
      end else if (diff > DIFF_MAX) begin
        diff = DIFF_MAX;
      end
      rate = gain_term(gain_p, e) + gain_term(gain_i, integ) + gain_term(gain_d, diff);
      if (rate < RATE_MIN) begin
        rate = RATE_MIN;
      end else if (rate > RATE_MAX) begin
        rate = RATE_MAX;
      end
      ctl = ctl_held + scaled_product(last_rate + rate, dt, FB + 1);
      // With crossed limits the lower bound wins only for values below it.
      if (ctl < ctl_lo) begin
        ctl = ctl_lo;
      end else if (ctl > ctl_hi) begin
        ctl = ctl_hi;
      end
      last_err = e;
      integ_sum = integ;
      last_rate = rate;
      ctl_held = ctl;
    end
    return ctl_held[DATA_W-1:0];
  endfunction

  // Input side: one transaction held until accepted, gaps only between transactions.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_controls.push_back(next_control(cur_cmd));
    end
    if (!in_valid_i || in_ready_o) begin
      if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
        cur_cmd = cmd_queue.pop_front();
        in_valid_i <= 1'b1;
        opcode_i <= cur_cmd.op;
        error_sample_i <= cur_cmd.err;
        time_step_i <= cur_cmd.dt;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_controls.size() == 0) begin
        $error("control_value: no transaction expected, actual %0d", control_value_o);
        fail_count++;
      end else begin
        want = expected_controls.pop_front();
        if (control_value_o !== want) begin
          $error("control_value: expected %0d, actual %0d", want, control_value_o);
          fail_count++;
        end
        done_count++;
      end
    end
    out_ready_i <= calm || ($urandom_range(99) >= 33);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GAIN_PROP:      gain_p = $signed(val);
      CFG_GAIN_INTEG:     gain_i = $signed(val);
      CFG_GAIN_DERIV:     gain_d = $signed(val);
      CFG_INTEGRAL_LIMIT: integ_lim = val[LIMIT_W-1:0];
      CFG_CONTROL_MIN:    ctl_lo = $signed(val);
      CFG_CONTROL_MAX:    ctl_hi = $signed(val);
      CFG_CONTROL_START:  ctl_start = $signed(val);
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] err,
                           input logic [DATA_W-1:0] dt);
    pid_cmd_t c;
    c.op = op;
    c.err = err;
    c.dt = dt;
    cmd_queue.push_back(c);
    issued_count++;
  endtask

  task automatic drain(input int unsigned extra);
    while (done_count != issued_count) begin
      @(posedge clk_i);
    end
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] random_gain();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
    end else if (pick < 85) begin
      return $urandom;
    end
    return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
  endfunction

  function automatic pid_cmd_t random_cmd();
    pid_cmd_t    c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 82) begin
      c.op = OP_UPDATE;
    end else if (pick < 89) begin
      c.op = OP_CLEAR;
    end else if (pick < 95) begin
      c.op = OP_RESTART;
    end else begin
      c.op = OP_UNUSED;
    end
    pick = $urandom_range(9);
    if (pick < 6) begin
      c.err = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    end else if (pick < 9) begin
      c.err = $urandom;
    end else begin
      c.err = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    end
    pick = $urandom_range(19);
    if (pick == 0) begin
      c.dt = '0;
    end else if (pick < 15) begin
      c.dt = $urandom_range(1, 32'h2_0000);
    end else if (pick < 18) begin
      c.dt = $urandom_range(1, 255);
    end else begin
      c.dt = $urandom;
    end
    return c;
  endfunction

  initial begin
    pid_cmd_t         c;
    logic [DATA_W-1:0] lo, hi, lim;
    int unsigned      pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults: all gains zero, so the output stays at the start value.
    queue_cmd(OP_UPDATE, 32'h0001_0000, 32'h0001_0000);
    queue_cmd(OP_RESTART, 32'h0, 32'h0);
    queue_cmd(OP_UNUSED, 32'h1234_5678, 32'h0001_0000);
    drain(4);

    write_reg(CFG_GAIN_PROP, 32'h0000_8000);
    write_reg(CFG_GAIN_INTEG, 32'h0000_4000);
    write_reg(CFG_GAIN_DERIV, 32'h0000_1000);
    write_reg(CFG_INTEGRAL_LIMIT, 32'h000a_0000);
    write_reg(CFG_CONTROL_MIN, 32'hff9c_0000);
    write_reg(CFG_CONTROL_MAX, 32'h0064_0000);
    write_reg(CFG_CONTROL_START, 32'h0005_0000);
    write_reg(CFG_UNUSED, 32'hdead_beef);
    queue_cmd(OP_RESTART, 32'h0, 32'h0);
    queue_cmd(OP_UPDATE, 32'h0001_0000, 32'h0001_0000);
    queue_cmd(OP_UPDATE, 32'h0002_0000, 32'h0000_8000);
    queue_cmd(OP_UPDATE, 32'hfffd_0000, 32'h0);
    queue_cmd(OP_UNUSED, 32'h8765_4321, 32'hffff_ffff);
    queue_cmd(OP_CLEAR, 32'h0, 32'h0);
    queue_cmd(OP_UPDATE, 32'h7fff_ffff, 32'h1);
    queue_cmd(OP_UPDATE, 32'h8000_0000, 32'h1);
    queue_cmd(OP_UPDATE, 32'h8000_0000, 32'hffff_ffff);
    queue_cmd(OP_UPDATE, 32'h7fff_ffff, 32'hffff_ffff);
    queue_cmd(OP_RESTART, 32'h0, 32'h0);
    queue_cmd(OP_UPDATE, 32'hffff_ffff, 32'h1);
    drain(4);

    // Extreme gains with the integral pinned at zero.
    write_reg(CFG_GAIN_PROP, 32'h7fff_ffff);
    write_reg(CFG_GAIN_INTEG, 32'h8000_0000);
    write_reg(CFG_GAIN_DERIV, 32'h7fff_ffff);
    write_reg(CFG_INTEGRAL_LIMIT, 32'h0);
    write_reg(CFG_CONTROL_MIN, 32'h8000_0000);
    write_reg(CFG_CONTROL_MAX, 32'h7fff_ffff);
    queue_cmd(OP_UPDATE, 32'h7fff_ffff, 32'hffff_ffff);
    queue_cmd(OP_UPDATE, 32'h8000_0000, 32'hffff_ffff);
    queue_cmd(OP_UPDATE, 32'h8000_0000, 32'h1);
    drain(4);
    // The top bit of the limit is dropped by the register.
    write_reg(CFG_INTEGRAL_LIMIT, 32'hffff_ffff);
    queue_cmd(OP_UPDATE, 32'h0001_0000, 32'h0001_0000);
    queue_cmd(OP_UPDATE, 32'h4000_0000, 32'h7fff_0000);
    drain(4);

    // Crossed control limits.
    write_reg(CFG_GAIN_PROP, 32'h0001_0000);
    write_reg(CFG_GAIN_INTEG, 32'h0);
    write_reg(CFG_GAIN_DERIV, 32'h0);
    write_reg(CFG_CONTROL_MIN, 32'h000a_0000);
    write_reg(CFG_CONTROL_MAX, 32'hfff6_0000);
    queue_cmd(OP_RESTART, 32'h0, 32'h0);
    queue_cmd(OP_UPDATE, 32'hffce_0000, 32'h0001_0000);
    queue_cmd(OP_UPDATE, 32'h0032_0000, 32'h0001_0000);
    queue_cmd(OP_UPDATE, 32'h0, 32'h0002_0000);
    drain(4);

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_GAIN_PROP, random_gain());
      write_reg(CFG_GAIN_INTEG, random_gain());
      write_reg(CFG_GAIN_DERIV, random_gain());
      pick = $urandom_range(99);
      if (pick < 60) begin
        lim = $urandom_range(0, 32'h40_0000);
      end else if (pick < 80) begin
        lim = $urandom;
      end else if (pick < 90) begin
        lim = '0;
      end else begin
        lim = 32'h7fff_ffff;
      end
      write_reg(CFG_INTEGRAL_LIMIT, lim);
      pick = $urandom_range(99);
      if (pick < 60) begin
        lo = 32'd0 - $urandom_range(1, 32'h100_0000);
        hi = $urandom_range(1, 32'h100_0000);
      end else if (pick < 75) begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end else if (pick < 90) begin
        lo = $urandom_range(0, 32'h100_0000);
        hi = 32'd0 - $urandom_range(0, 32'h100_0000);
      end else begin
        lo = $urandom;
        hi = $urandom;
      end
      write_reg(CFG_CONTROL_MIN, lo);
      write_reg(CFG_CONTROL_MAX, hi);
      write_reg(CFG_CONTROL_START,
                $urandom_range(1) ? ($urandom_range(0, 32'h20_0000) - 32'h10_0000) : $urandom);
      if ($urandom_range(2) == 0) begin
        write_reg(CFG_UNUSED, $urandom);
      end
      // One phase runs with both sides at full rate.
      calm = (p == 2);
      repeat (125) begin
        c = random_cmd();
        queue_cmd(c.op, c.err, c.dt);
      end
      drain(4);
    end
    calm = 1'b0;

    drain(120);
    if (fail_count == 0) begin
      $display("PASS pid_velocity_form_trapezoid");
    end else begin
      $display("FAIL pid_velocity_form_trapezoid");
    end
    $finish;
  end

endmodule

@@ pid_velocity_form_trapezoid.f @@
hw/rtl/pidvf_pkg.sv
hw/rtl/pid_velocity_form_trapezoid.sv
hw/rtl/pidvf_checker.sv
sim/testbench.sv
